FILE: src/gte_pkg.sv
// Shared constants and types for the graph traversal engine.
`default_nettype none

package gte_pkg;

    localparam int DEF_MAX_VERTICES = 16;

    localparam logic [1:0] OP_ADD_EDGE = 2'd0;
    localparam logic [1:0] OP_BFS      = 2'd1;
    localparam logic [1:0] OP_DFS      = 2'd2;

    localparam logic       REG_VERTEX_COUNT = 1'b0;
    localparam logic [4:0] VERTEX_COUNT_RESET = 5'd16;

    typedef struct packed {
        logic go;
        logic dfs;
    } trav_cmd_t;

endpackage

`default_nettype wire

FILE: src/gte_adj_store.sv
// Bit adjacency matrix with a symmetric edge write and one row read port.
`default_nettype none

module gte_adj_store #(
    parameter int MAX_VERTICES = gte_pkg::DEF_MAX_VERTICES,
    localparam int IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    we,
    input  wire logic [IDX_W-1:0]        wu,
    input  wire logic [IDX_W-1:0]        wv,
    input  wire logic [IDX_W-1:0]        raddr,
    output logic      [MAX_VERTICES-1:0] rdata
);

    import gte_pkg::*;

    logic [MAX_VERTICES-1:0] adj_reg [MAX_VERTICES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < MAX_VERTICES; r++)
            begin
                adj_reg[r] <= '0;
            end
        end
        else if (we)
        begin
            for (int r = 0; r < MAX_VERTICES; r++)
            begin
                if (IDX_W'(r) == wu)
                begin
                    adj_reg[r][wv] <= 1'b1;
                end
                else if (IDX_W'(r) == wv)
                begin
                    adj_reg[r][wu] <= 1'b1;
                end
            end
        end
    end

    assign rdata = adj_reg[raddr];

endmodule

`default_nettype wire

FILE: src/gte_scan_unit.sv
// Neighbour test unit: checks one candidate vertex of a row per cycle while the sequencer scans.
`default_nettype none

module gte_scan_unit #(
    parameter int MAX_VERTICES = gte_pkg::DEF_MAX_VERTICES,
    localparam int IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
    localparam int CNT_W = $clog2(MAX_VERTICES + 1)
) (
    input  wire logic [MAX_VERTICES-1:0] row,
    input  wire logic [MAX_VERTICES-1:0] visited,
    input  wire logic [CNT_W-1:0]        idx,
    input  wire logic [CNT_W-1:0]        count,
    output logic                         hit,
    output logic                         at_end
);

    import gte_pkg::*;

    assign at_end = (idx >= count);
    assign hit    = !at_end && row[idx[IDX_W-1:0]] && !visited[idx[IDX_W-1:0]];

endmodule

`default_nettype wire

FILE: src/gte_seq.sv
// Traversal sequencer with breadth-first queue, depth-first stack and result register.
`default_nettype none

module gte_seq #(
    parameter int MAX_VERTICES = gte_pkg::DEF_MAX_VERTICES,
    localparam int IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
    localparam int CNT_W = $clog2(MAX_VERTICES + 1)
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  gte_pkg::trav_cmd_t           cmd,
    input  wire logic [IDX_W-1:0]        start,
    input  wire logic [CNT_W-1:0]        count,
    input  wire logic [MAX_VERTICES-1:0] adj_row,
    output logic      [IDX_W-1:0]        adj_addr,
    output logic                         idle,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic      [3:0]              out_vertex,
    output logic                         out_last
);

    import gte_pkg::*;

    localparam int SE_W = CNT_W + IDX_W;

    typedef enum logic [7:0] {
        S_IDLE        = 8'b0000_0001,
        S_BFS_POP     = 8'b0000_0010,
        S_BFS_EMIT    = 8'b0000_0100,
        S_BFS_SCAN    = 8'b0000_1000,
        S_DFS_EMIT    = 8'b0001_0000,
        S_DFS_SCAN    = 8'b0010_0000,
        S_DFS_RESTORE = 8'b0100_0000,
        S_FINISH      = 8'b1000_0000
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        head_reg, head_next;
    logic [CNT_W-1:0]        tail_reg, tail_next;
    logic [CNT_W-1:0]        depth_reg, depth_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic [IDX_W-1:0]        cur_v_reg, cur_v_next;
    logic [IDX_W-1:0]        cand_reg, cand_next;
    logic [MAX_VERTICES-1:0] row_reg, row_next;
    logic [MAX_VERTICES-1:0] vis_reg, vis_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]        pend_v_reg, pend_v_next;
    logic                    out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]        out_v_reg, out_v_next;
    logic                    out_last_reg, out_last_next;

    logic [IDX_W-1:0]        queue_mem [MAX_VERTICES];
    logic [SE_W-1:0]         stack_mem [MAX_VERTICES];
    logic [IDX_W-1:0]        q_rd_reg;
    logic [SE_W-1:0]         stk_rd_reg;

    logic                    q_we, q_re, s_we, s_re;
    logic [IDX_W-1:0]        q_waddr, q_wdata, q_raddr, s_waddr, s_raddr;
    logic [SE_W-1:0]         s_wdata;

    logic                    hit, at_end;
    logic                    emit_req, emit_done, emit_ok, fin_done;
    logic [IDX_W-1:0]        emit_v;

    gte_scan_unit #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_scan (
        .row    (row_reg),
        .visited(vis_reg),
        .idx    (idx_reg),
        .count  (count),
        .hit    (hit),
        .at_end (at_end)
    );

    assign emit_ok = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        depth_next      = depth_reg;
        idx_next        = idx_reg;
        cur_v_next      = cur_v_reg;
        cand_next       = cand_reg;
        row_next        = row_reg;
        vis_next        = vis_reg;
        adj_addr        = cand_reg;
        emit_req        = 1'b0;
        emit_v          = cand_reg;
        fin_done        = 1'b0;
        q_we            = 1'b0;
        q_waddr         = tail_reg[IDX_W-1:0];
        q_wdata         = start;
        q_re            = 1'b0;
        q_raddr         = head_reg[IDX_W-1:0];
        s_we            = 1'b0;
        s_waddr         = IDX_W'(depth_reg - CNT_W'(1));
        s_wdata         = {CNT_W'(idx_reg + CNT_W'(1)), cur_v_reg};
        s_re            = 1'b0;
        s_raddr         = IDX_W'(depth_reg - CNT_W'(2));

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.go)
                begin
                    vis_next        = '0;
                    vis_next[start] = 1'b1;
                    if (cmd.dfs)
                    begin
                        depth_next = '0;
                        cand_next  = start;
                        state_next = S_DFS_EMIT;
                    end
                    else
                    begin
                        q_we       = 1'b1;
                        q_waddr    = '0;
                        head_next  = '0;
                        tail_next  = CNT_W'(1);
                        state_next = S_BFS_POP;
                    end
                end
            end
            S_BFS_POP:
            begin
                if (head_reg == tail_reg)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    q_re       = 1'b1;
                    head_next  = head_reg + CNT_W'(1);
                    state_next = S_BFS_EMIT;
                end
            end
            S_BFS_EMIT:
            begin
                emit_req = 1'b1;
                emit_v   = q_rd_reg;
                adj_addr = q_rd_reg;
                if (emit_done)
                begin
                    row_next   = adj_row;
                    idx_next   = '0;
                    state_next = S_BFS_SCAN;
                end
            end
            S_BFS_SCAN:
            begin
                if (at_end)
                begin
                    state_next = S_BFS_POP;
                end
                else
                begin
                    if (hit && (32'(tail_reg) < MAX_VERTICES))
                    begin
                        q_we                         = 1'b1;
                        q_wdata                      = idx_reg[IDX_W-1:0];
                        tail_next                    = tail_reg + CNT_W'(1);
                        vis_next[idx_reg[IDX_W-1:0]] = 1'b1;
                    end
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            S_DFS_EMIT:
            begin
                emit_req = 1'b1;
                emit_v   = cand_reg;
                adj_addr = cand_reg;
                if (emit_done)
                begin
                    row_next   = adj_row;
                    cur_v_next = cand_reg;
                    idx_next   = '0;
                    depth_next = depth_reg + CNT_W'(1);
                    state_next = S_DFS_SCAN;
                end
            end
            S_DFS_SCAN:
            begin
                if (!at_end && !hit)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
                else if (hit && (32'(depth_reg) < MAX_VERTICES))
                begin
                    s_we                         = 1'b1;
                    vis_next[idx_reg[IDX_W-1:0]] = 1'b1;
                    cand_next                    = idx_reg[IDX_W-1:0];
                    state_next                   = S_DFS_EMIT;
                end
                else
                begin
                    depth_next = depth_reg - CNT_W'(1);
                    if (depth_reg == CNT_W'(1))
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        s_re       = 1'b1;
                        state_next = S_DFS_RESTORE;
                    end
                end
            end
            S_DFS_RESTORE:
            begin
                adj_addr   = stk_rd_reg[IDX_W-1:0];
                row_next   = adj_row;
                cur_v_next = stk_rd_reg[IDX_W-1:0];
                idx_next   = stk_rd_reg[SE_W-1:IDX_W];
                state_next = S_DFS_SCAN;
            end
            S_FINISH:
            begin
                if (emit_ok)
                begin
                    fin_done   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign emit_done = emit_req && emit_ok;

    always_comb
    begin
        out_valid_next  = out_valid_reg && !out_ready;
        out_v_next      = out_v_reg;
        out_last_next   = out_last_reg;
        pend_valid_next = pend_valid_reg;
        pend_v_next     = pend_v_reg;
        if (emit_done)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_v_next     = pend_v_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_v_next     = emit_v;
        end
        if (fin_done)
        begin
            out_valid_next  = 1'b1;
            out_v_next      = pend_v_reg;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            depth_reg      <= '0;
            vis_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            depth_reg      <= depth_next;
            vis_reg        <= vis_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        cur_v_reg    <= cur_v_next;
        cand_reg     <= cand_next;
        row_reg      <= row_next;
        pend_v_reg   <= pend_v_next;
        out_v_reg    <= out_v_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            queue_mem[q_waddr] <= q_wdata;
        end
        if (q_re)
        begin
            q_rd_reg <= queue_mem[q_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            stack_mem[s_waddr] <= s_wdata;
        end
        if (s_re)
        begin
            stk_rd_reg <= stack_mem[s_raddr];
        end
    end

    assign idle       = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_vertex = 4'(out_v_reg);
    assign out_last   = out_last_reg;

endmodule

`default_nettype wire

FILE: src/graph_traversal_engine_top.sv
// An add-edge transfer keeps the sequencer idle and the block is ready again in the next cycle.
// A traversal reads the matrix row of each vertex it reaches, breadth-first or
// depth-first; the single neighbour test unit checks one matrix bit per cycle while
// a row is scanned, up to the vertex count in use, and pauses while a vertex waits.
// A result leaves once the next vertex is emitted or the traversal ends.
// Asynchronous active-low reset clears the matrix and sets vertex_count to 16.
`default_nettype none

module graph_traversal_engine_top #(
    parameter int MAX_VERTICES = gte_pkg::DEF_MAX_VERTICES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // opcode[1:0], edge_u[5:2], edge_v[9:6], start_vertex[13:10], zero[15:14]
    input  wire logic [15:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // visited_vertex[3:0], zero[7:4]
    output logic      [7:0]  m_tdata,
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    import gte_pkg::*;

    localparam int IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);

    logic [4:0]              vc_reg;
    logic [CNT_W-1:0]        count;
    logic [1:0]              opcode;
    logic [3:0]              edge_u, edge_v, start_vertex;
    logic                    accept, seq_idle, adj_we;
    trav_cmd_t               cmd;
    logic [IDX_W-1:0]        adj_addr;
    logic [MAX_VERTICES-1:0] adj_row;
    logic [3:0]              out_vertex;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= VERTEX_COUNT_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_VERTEX_COUNT))
        begin
            vc_reg <= pwdata[4:0];
        end
    end

    assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? {27'd0, vc_reg} : 32'd0;

    assign count = (32'(vc_reg) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES) : CNT_W'(vc_reg);

    assign opcode       = s_tdata[1:0];
    assign edge_u       = s_tdata[5:2];
    assign edge_v       = s_tdata[9:6];
    assign start_vertex = s_tdata[13:10];

    assign s_tready = seq_idle && rst_n;
    assign accept   = s_tvalid && s_tready;

    assign adj_we  = accept && (opcode == OP_ADD_EDGE)
                     && (32'(edge_u) < 32'(count)) && (32'(edge_v) < 32'(count));
    assign cmd     = '{go: accept && ((opcode == OP_BFS) || (opcode == OP_DFS))
                           && (32'(start_vertex) < 32'(count)),
                       dfs: (opcode == OP_DFS)};

    gte_adj_store #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_adj (
        .clk  (clk),
        .rst_n(rst_n),
        .we   (adj_we),
        .wu   (IDX_W'(edge_u)),
        .wv   (IDX_W'(edge_v)),
        .raddr(adj_addr),
        .rdata(adj_row)
    );

    gte_seq #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .start     (IDX_W'(start_vertex)),
        .count     (count),
        .adj_row   (adj_row),
        .adj_addr  (adj_addr),
        .idle      (seq_idle),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_vertex(out_vertex),
        .out_last  (m_tlast)
    );

    assign m_tdata = {4'd0, out_vertex};

endmodule

`default_nettype wire

FILE: src/gte_checker.sv
// Port-level assertions for the graph traversal engine and their bind.
`default_nettype none

module gte_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [15:0] s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata,
    input wire logic        m_tlast
);

    import gte_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("Result changed while a transfer was stalled.");

    a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:4] == 4'd0))
        else $error("Result padding bits are not zero.");

    a_edge_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tdata[1:0] == OP_ADD_EDGE) |=> s_tready)
        else $error("Block not ready after an add-edge transfer.");

endmodule

bind graph_traversal_engine_top gte_checker u_gte_checker (.*);

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the graph traversal engine: BFS and DFS visit order against a predictor.
`timescale 1ns / 100ps

module testbench;
    import gte_pkg::*;

    localparam int         LIMIT     = 1000000;
    localparam int         DRAIN     = 400;
    localparam int         VERTS     = 16;
    localparam int         PER_PHASE = 36;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [2:0] REG_ADDR  = {REG_VERTEX_COUNT, 2'b00};
    localparam logic [4:0] PHASE_COUNT [11] = '{5'd16, 5'd1, 5'd2, 5'd5, 5'd0, 5'd9,
                                                5'd16, 5'd31, 5'd17, 5'd12, 5'd16};

    typedef struct {
        logic [3:0] vertex;
        logic       last;
    } visit_t;

    class traversal_scoreboard;
        logic [4:0]  count_reg;
        logic [15:0] adj [VERTS];
        visit_t      visits [$];
        visit_t      walk [$];
        int          errors;
        int          checked;
        int          walks;

        function new();
            count_reg = VERTEX_COUNT_RESET;
            foreach (adj[i]) adj[i] = '0;
            errors = 0;
            checked = 0;
            walks = 0;
        endfunction

        function void set_count(logic [4:0] c);
            count_reg = c;
        endfunction

        function int span();
            return (count_reg > VERTS) ? VERTS : int'(count_reg);
        endfunction

        function int pending();
            return visits.size();
        endfunction

        function void visit(int v);
            visit_t e;
            if (walk.size() < VERTS)
            begin
                e.vertex = 4'(v);
                e.last = 1'b0;
                walk.insert(walk.size(), e);
            end
        endfunction

        function void breadth_first(int s, int n);
            int          fifo [VERTS];
            int          head;
            int          tail;
            int          cur;
            logic [15:0] seen;
            head = 0;
            tail = 1;
            fifo[0] = s;
            seen = '0;
            seen[s] = 1'b1;
            while (head < tail)
            begin
                cur = fifo[head];
                head++;
                visit(cur);
                for (int i = 0; i < n; i++)
                begin
                    if (adj[cur][i] && !seen[i] && tail < VERTS)
                    begin
                        fifo[tail] = i;
                        tail++;
                        seen[i] = 1'b1;
                    end
                end
            end
        endfunction

        function void depth_first(int s, int n);
            int          stk_v [VERTS];
            int          stk_i [VERTS];
            int          depth;
            int          v;
            int          i;
            bit          found;
            logic [15:0] seen;
            depth = 1;
            stk_v[0] = s;
            stk_i[0] = 0;
            seen = '0;
            seen[s] = 1'b1;
            visit(s);
            while (depth > 0)
            begin
                v = stk_v[depth - 1];
                i = stk_i[depth - 1];
                found = 1'b0;
                while (i < n && !found)
                begin
                    if (adj[v][i] && !seen[i])
                        found = 1'b1;
                    else
                        i++;
                end
                if (found && depth < VERTS)
                begin
                    stk_i[depth - 1] = i + 1;
                    seen[i] = 1'b1;
                    visit(i);
                    stk_v[depth] = i;
                    stk_i[depth] = 0;
                    depth++;
                end
                else
                    depth--;
            end
        endfunction

        // Returns whether the transfer acted on the graph rather than being dropped.
        function bit note_input(logic [15:0] d);
            logic [1:0] op;
            int         u;
            int         v;
            int         s;
            int         n;
            op = d[1:0];
            u = d[5:2];
            v = d[9:6];
            s = d[13:10];
            n = span();
            if (op == OP_ADD_EDGE)
            begin
                if (u < n && v < n)
                begin
                    adj[u][v] = 1'b1;
                    adj[v][u] = 1'b1;
                    return 1'b1;
                end
                return 1'b0;
            end
            if (!(op == OP_BFS || op == OP_DFS) || s >= n)
                return 1'b0;
            walk.delete();
            if (op == OP_BFS)
                breadth_first(s, n);
            else
                depth_first(s, n);
            walk[walk.size() - 1].last = 1'b1;
            foreach (walk[k]) visits.insert(visits.size(), walk[k]);
            walks++;
            return 1'b1;
        endfunction

        function void check_result(logic [3:0] vtx, logic lst);
            visit_t want;
            checked++;
            if (visits.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected vertex %0d (last %0b) with nothing outstanding",
                         $time, vtx, lst);
                return;
            end
            want = visits.pop_front();
            if (vtx !== want.vertex)
            begin
                errors++;
                $display("%0t: visited_vertex expected %0d actual %0d",
                         $time, want.vertex, vtx);
            end
            if (lst !== want.last)
            begin
                errors++;
                $display("%0t: last expected %0b actual %0b", $time, want.last, lst);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    traversal_scoreboard sb;
    int src_idle;
    int sink_stall;
    int hold_left;
    int cycle_count;
    int items_sent;
    int items_acting;

    graph_traversal_engine_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= sink_stall);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata[3:0], m_tlast);
    end

    function automatic logic [15:0] pack(logic [1:0] op, logic [3:0] u, logic [3:0] v,
                                         logic [3:0] s);
        return {2'b00, s, v, u, op};
    endfunction

    function automatic logic [15:0] random_item(int n);
        int         r;
        logic [1:0] op;
        logic [3:0] u;
        logic [3:0] v;
        logic [3:0] s;
        u = 4'($urandom);
        v = 4'($urandom);
        s = 4'($urandom);
        r = $urandom_range(99);
        if (n == 0 || r >= 80)
        begin
            case ($urandom_range(2))
                0: op = OP_UNUSED;
                1: op = 2'($urandom_range(2));
                default:
                begin
                    op = 2'($urandom_range(2));
                    if (n < VERTS)
                    begin
                        s = 4'($urandom_range(15, n));
                        if ($urandom_range(1))
                            u = 4'($urandom_range(15, n));
                        else
                            v = 4'($urandom_range(15, n));
                    end
                end
            endcase
        end
        else if (r < 40)
        begin
            op = OP_ADD_EDGE;
            u = 4'($urandom_range(n - 1));
            v = 4'($urandom_range(n - 1));
        end
        else
        begin
            op = $urandom_range(1) ? OP_DFS : OP_BFS;
            s = 4'($urandom_range(n - 1));
        end
        return pack(op, u, v, s);
    endfunction

    task automatic send_item(input logic [15:0] d, output bit acting);
        while ($urandom_range(99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        do @(posedge clk); while (!s_tready);
        acting = sb.note_input(d);
        items_sent++;
        if (acting)
            items_acting++;
    endtask

    task automatic settle();
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_vertex_count(input logic [4:0] c);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_ADDR;
        pwdata <= {27'($urandom), c};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_count(c);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_mix(input int mode);
        case (mode)
            0: begin src_idle = 0;  sink_stall = 0;  end
            1: begin src_idle = 51; sink_stall = 0;  end
            2: begin src_idle = 0;  sink_stall = 51; end
            default: begin src_idle = 17; sink_stall = 17; end
        endcase
    endtask

    task automatic send_list(input logic [15:0] list [$]);
        bit acting;
        foreach (list[i]) send_item(list[i], acting);
        s_tvalid <= 1'b0;
        settle();
    endtask

    initial
    begin
        logic [15:0] directed [$];
        bit          acting;
        int          done;
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_left = 0;
        cycle_count = 0;
        items_sent = 0;
        items_acting = 0;
        sb = new();
        set_mix(0);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty graph, a self loop, then a small graph where BFS and DFS orders differ.
        directed = '{pack(OP_BFS, 0, 0, 0), pack(OP_DFS, 15, 15, 15),
                     pack(OP_ADD_EDGE, 3, 3, 0), pack(OP_DFS, 0, 0, 3),
                     pack(OP_ADD_EDGE, 0, 1, 0), pack(OP_ADD_EDGE, 0, 2, 0),
                     pack(OP_ADD_EDGE, 1, 3, 0), pack(OP_ADD_EDGE, 2, 3, 0),
                     pack(OP_ADD_EDGE, 3, 15, 0), pack(OP_ADD_EDGE, 15, 14, 0),
                     pack(OP_BFS, 0, 0, 0), pack(OP_DFS, 0, 0, 0),
                     pack(OP_UNUSED, 15, 15, 15), pack(OP_BFS, 0, 0, 15)};
        send_list(directed);

        // A smaller count hides the upper vertices and drops items that name them.
        write_vertex_count(5'd4);
        directed = '{pack(OP_ADD_EDGE, 0, 5, 0), pack(OP_ADD_EDGE, 5, 0, 0),
                     pack(OP_BFS, 0, 0, 3), pack(OP_DFS, 0, 0, 0),
                     pack(OP_BFS, 0, 0, 4), pack(OP_DFS, 0, 0, 15)};
        send_list(directed);

        write_vertex_count(5'd0);
        directed = '{pack(OP_BFS, 0, 0, 0), pack(OP_ADD_EDGE, 0, 1, 0)};
        send_list(directed);

        // A count above the limit is clamped, so the hidden vertices return.
        write_vertex_count(5'd31);
        directed = '{pack(OP_DFS, 0, 0, 14), pack(OP_BFS, 0, 0, 0)};
        send_list(directed);

        foreach (PHASE_COUNT[p])
        begin
            write_vertex_count(PHASE_COUNT[p]);
            set_mix(p % 4);
            if (p == 6)
                hold_left = 1500;
            done = 0;
            if (PHASE_COUNT[p] == 0)
            begin
                repeat (12) send_item(random_item(0), acting);
            end
            else
            begin
                while (done < PER_PHASE)
                begin
                    send_item(random_item(sb.span()), acting);
                    if (acting)
                        done++;
                end
            end
            s_tvalid <= 1'b0;
            settle();
        end

        $display("Run sent %0d transfers (%0d acted on the graph), %0d traversals, %0d results.",
                 items_sent, items_acting, sb.walks, sb.checked);
        $display("Vertex counts 0 to 31 incl. clamping, four idling mixes and one long stall.");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
